/* rtl/lagr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lagr_pkg
// Types and codes shared by the ARQ gap/retransmit unit.
// ----------------------------------------------------------------------------
package lagr_pkg;

  localparam logic [1:0] CMD_SENT = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_PUMP = 2'd2;

  localparam logic [1:0] OP_SENT = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_PUMP = 2'd2;

  localparam logic [1:0] REG_ARQ_ENABLE  = 2'd0;
  localparam logic [1:0] REG_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] REG_SECOND_DLY  = 2'd2;
  localparam logic [1:0] REG_GAP_CAP     = 2'd3;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_ORDER   = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] seq_num;
    logic [1:0]  free_slots;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] out_seq;
    logic [7:0]  history_slot;
    logic        deliver;
    logic        duplicate;
    logic        gap_seen;
    logic        refilled;
    logic        last;
  } out_t;

  typedef struct packed {
    logic       arq_enable;
    logic [3:0] retry_limit;
    logic [7:0] second_copy_delay;
    logic [8:0] gap_request_cap;
  } cfg_t;

  // classified work between front and back
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] seq;
    logic [1:0]  credits;
  } work_t;

endpackage
`default_nettype wire

/* rtl/lagr_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lagr_front
// Accepts input items, classifies them and queues work for the engine.
// ----------------------------------------------------------------------------
module lagr_front #(
  parameter int TX_CREDITS = 2
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  lagr_pkg::in_t     item,
  output logic              full,
  input  wire               hold,
  input  wire               arq_enable,
  output logic              wq_empty,
  output lagr_pkg::work_t   wq_data,
  input  wire               wq_pop
);

  lagr_pkg::work_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic            accept;
  logic            keep;
  lagr_pkg::work_t cls;

  assign full     = hold || (count == 2'd2);
  assign accept   = push && !full;
  assign wq_empty = (count == 2'd0);
  assign wq_data  = slots[rd_ptr];

  always_comb begin
    cls.seq = item.seq_num;
    if (5'(item.free_slots) < 5'(TX_CREDITS)) begin
      cls.credits = item.free_slots;
    end else begin
      cls.credits = 2'(TX_CREDITS);
    end
    keep = 1'b0;
    cls.op = lagr_pkg::OP_RECV;
    unique case (item.cmd)
      lagr_pkg::CMD_SENT: begin
        cls.op = lagr_pkg::OP_SENT;
        keep   = arq_enable;
      end
      lagr_pkg::CMD_RECV: begin
        cls.op = lagr_pkg::OP_RECV;
        keep   = 1'b1;
      end
      lagr_pkg::CMD_PUMP: begin
        cls.op = lagr_pkg::OP_PUMP;
        keep   = arq_enable;
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (accept && keep) begin
        wr_ptr <= !wr_ptr;
      end
      if (wq_pop && !wq_empty) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(accept && keep) - 2'(wq_pop && !wq_empty);
    end
  end

endmodule
`default_nettype wire

/* rtl/lagr_out_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lagr_out_fifo
// Small result queue between the engine and the result ports.
// ----------------------------------------------------------------------------
module lagr_out_fifo (
  input  wire            clk,
  input  wire            rst,
  input  wire            wr,
  input  lagr_pkg::out_t wdata,
  output logic           ofull,
  input  wire            pop,
  output logic           empty,
  output lagr_pkg::out_t result
);

  lagr_pkg::out_t slots [4];
  logic [1:0]     wr_ptr;
  logic [1:0]     rd_ptr;
  logic [2:0]     count;
  logic           do_wr;
  logic           do_rd;

  assign ofull  = (count == 3'd4);
  assign empty  = (count == 3'd0);
  assign result = slots[rd_ptr];
  assign do_wr  = wr && !ofull;
  assign do_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + 3'(do_wr) - 3'(do_rd);
    end
  end

endmodule
`default_nettype wire

/* rtl/lagr_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lagr_engine
// Back end sequencer: history, dedup ring, request and second-copy queues.
// ----------------------------------------------------------------------------
module lagr_engine #(
  parameter int HIST_DEPTH      = 256,
  parameter int REQ_QUEUE_DEPTH = 512,
  parameter int SEEN_DEPTH      = 512
) (
  input  wire             clk,
  input  wire             rst,
  input  lagr_pkg::cfg_t  cfg,
  input  wire             wq_empty,
  input  lagr_pkg::work_t wq_data,
  output logic            wq_pop,
  output logic            clearing,
  output logic            out_wr,
  output lagr_pkg::out_t  out_data,
  input  wire             out_full
);

  localparam int HW  = $clog2(HIST_DEPTH);
  localparam int QW  = (REQ_QUEUE_DEPTH > 1) ? $clog2(REQ_QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(REQ_QUEUE_DEPTH + 1);
  localparam int SW  = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_SENT     = 4'd2;
  localparam logic [3:0] S_RECV     = 4'd3;
  localparam logic [3:0] S_SRCH     = 4'd4;
  localparam logic [3:0] S_DECIDE   = 4'd5;
  localparam logic [3:0] S_GAP      = 4'd6;
  localparam logic [3:0] S_VERDICT  = 4'd7;
  localparam logic [3:0] S_SC_CHECK = 4'd8;
  localparam logic [3:0] S_SC_DATA  = 4'd9;
  localparam logic [3:0] S_SC_AFTER = 4'd10;
  localparam logic [3:0] S_RX_CHECK = 4'd11;
  localparam logic [3:0] S_RX_DATA  = 4'd12;
  localparam logic [3:0] S_RX_HIST  = 4'd13;
  localparam logic [3:0] S_FIN      = 4'd14;

  logic [3:0]      state;
  logic [3:0]      ret;
  lagr_pkg::work_t w;

  // memories
  logic [35:0] hist_mem [HIST_DEPTH];
  logic [31:0] rq_mem   [REQ_QUEUE_DEPTH];
  logic [95:0] sc_mem   [REQ_QUEUE_DEPTH];
  logic [31:0] ring_mem [SEEN_DEPTH];

  logic [HIST_DEPTH-1:0] hist_valid;
  logic [35:0] hist_q;
  logic [31:0] rq_q;
  logic [95:0] sc_q;
  logic [31:0] ring_q;

  logic [QW-1:0]  rq_head, rq_tail, sc_head, sc_tail;
  logic [QCW-1:0] rq_count, sc_count;
  logic [SW-1:0]  seen_pos, srch_idx, clr_idx;
  logic           issued_all, cmp_v, hit;
  logic [31:0]    key;
  logic [63:0]    frame_tick;
  logic [31:0]    newest_seq;
  logic           any_received;
  logic [8:0]     gap_rem;
  logic [31:0]    gap_seq;
  logic [31:0]    cur_seq;
  logic [31:0]    pend_seq;
  logic           pend_valid;
  logic [1:0]     n;
  lagr_pkg::out_t verdict;

  // combinational controls
  logic          hist_we, hist_re;
  logic [HW-1:0] hist_waddr, hist_raddr, cur_slot;
  logic [35:0]   hist_wdata;
  logic          order_ok, can_go;
  logic          rq_we, rq_re, rq_room;
  logic [31:0]   rq_wdata;
  logic          sc_we, sc_re, sc_room;
  logic          ring_we;
  logic [SW-1:0] ring_waddr;
  logic [31:0]   ring_wdata;
  logic [31:0]   diff;
  logic [31:0]   diff_m1;

  assign clearing = (state == S_CLEAR);
  assign wq_pop   = (state == S_IDLE) && !wq_empty;
  assign cur_slot = cur_seq[HW-1:0];
  assign rq_room  = (rq_count < QCW'(REQ_QUEUE_DEPTH));
  assign sc_room  = (sc_count < QCW'(REQ_QUEUE_DEPTH));
  assign order_ok = hist_valid[cur_slot] && (hist_q[35:4] == cur_seq) &&
                    (hist_q[3:0] < cfg.retry_limit);
  assign can_go   = !pend_valid || !out_full;
  assign diff     = w.seq - newest_seq;
  assign diff_m1  = diff - 32'd1;

  always_comb begin
    hist_we    = 1'b0;
    hist_waddr = cur_slot;
    hist_wdata = {cur_seq, hist_q[3:0] + 4'd1};
    hist_re    = (state == S_RX_DATA);
    hist_raddr = rq_q[HW-1:0];
    rq_we      = 1'b0;
    rq_wdata   = key;
    rq_re      = (state == S_RX_CHECK) && (rq_count != '0) && (n < w.credits);
    sc_we      = 1'b0;
    sc_re      = (state == S_SC_CHECK) && (sc_count != '0);
    ring_we    = 1'b0;
    ring_waddr = seen_pos;
    ring_wdata = w.seq;
    out_wr     = 1'b0;
    out_data   = verdict;
    unique case (state)
      S_CLEAR: begin
        ring_we    = 1'b1;
        ring_waddr = clr_idx;
        ring_wdata = '1;
      end
      S_SENT: begin
        hist_we    = 1'b1;
        hist_waddr = w.seq[HW-1:0];
        hist_wdata = {w.seq, 4'd0};
      end
      S_DECIDE: ring_we = !hit;
      S_GAP: begin
        rq_we    = (gap_rem != 9'd0) && rq_room;
        rq_wdata = gap_seq;
      end
      S_VERDICT: out_wr = !out_full;
      S_SC_AFTER: rq_we = !hit && rq_room;
      S_RX_HIST: begin
        hist_we = order_ok && can_go;
        sc_we   = order_ok && can_go && (hist_q[3:0] == 4'd0) && sc_room;
        out_wr  = order_ok && pend_valid && !out_full;
      end
      S_FIN: out_wr = pend_valid && !out_full;
      default: ;
    endcase
    if (state == S_RX_HIST || state == S_FIN) begin
      out_data.kind         = lagr_pkg::KIND_ORDER;
      out_data.out_seq      = pend_seq;
      out_data.history_slot = 8'(pend_seq[HW-1:0]);
      out_data.deliver      = 1'b0;
      out_data.duplicate    = 1'b0;
      out_data.gap_seen     = 1'b0;
      out_data.refilled     = 1'b0;
      out_data.last         = (state == S_FIN);
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_q <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rq_we) begin
      rq_mem[rq_tail] <= rq_wdata;
    end
    if (rq_re) begin
      rq_q <= rq_mem[rq_head];
    end
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_tail] <= {frame_tick + 64'(cfg.second_copy_delay), cur_seq};
    end
    if (sc_re) begin
      sc_q <= sc_mem[sc_head];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= ring_wdata;
    end
    ring_q <= ring_mem[srch_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      ret          <= S_DECIDE;
      hist_valid   <= '0;
      rq_head      <= '0;
      rq_tail      <= '0;
      rq_count     <= '0;
      sc_head      <= '0;
      sc_tail      <= '0;
      sc_count     <= '0;
      seen_pos     <= '0;
      srch_idx     <= '0;
      clr_idx      <= '0;
      issued_all   <= 1'b0;
      cmp_v        <= 1'b0;
      hit          <= 1'b0;
      frame_tick   <= '0;
      newest_seq   <= '0;
      any_received <= 1'b0;
      gap_rem      <= '0;
      pend_valid   <= 1'b0;
      n            <= '0;
    end else begin
      if (rq_we) begin
        rq_tail  <= (rq_tail == QW'(REQ_QUEUE_DEPTH - 1)) ? '0 : rq_tail + QW'(1);
        rq_count <= rq_count + QCW'(1);
      end
      unique case (state)
        S_CLEAR: begin
          if (clr_idx == SW'(SEEN_DEPTH - 1)) begin
            state <= S_IDLE;
          end else begin
            clr_idx <= clr_idx + SW'(1);
          end
        end
        S_IDLE: begin
          if (!wq_empty) begin
            w <= wq_data;
            unique case (wq_data.op)
              lagr_pkg::OP_SENT: state <= S_SENT;
              lagr_pkg::OP_RECV: state <= S_RECV;
              default: begin
                n          <= '0;
                pend_valid <= 1'b0;
                state      <= S_SC_CHECK;
              end
            endcase
          end
        end
        S_SENT: begin
          hist_valid[w.seq[HW-1:0]] <= 1'b1;
          state <= S_IDLE;
        end
        S_RECV: begin
          frame_tick <= frame_tick + 64'd1;
          if (!cfg.arq_enable) begin
            verdict.kind         <= lagr_pkg::KIND_VERDICT;
            verdict.out_seq      <= w.seq;
            verdict.history_slot <= 8'd0;
            verdict.deliver      <= 1'b1;
            verdict.duplicate    <= 1'b0;
            verdict.gap_seen     <= any_received && (w.seq != newest_seq + 32'd1);
            verdict.refilled     <= 1'b0;
            verdict.last         <= 1'b1;
            newest_seq   <= w.seq;
            any_received <= 1'b1;
            state        <= S_VERDICT;
          end else begin
            key        <= w.seq;
            srch_idx   <= '0;
            issued_all <= 1'b0;
            cmp_v      <= 1'b0;
            hit        <= 1'b0;
            ret        <= S_DECIDE;
            state      <= S_SRCH;
          end
        end
        S_SRCH: begin
          // one ring read issued per cycle, each compared in the following cycle
          if (!issued_all) begin
            if (srch_idx == SW'(SEEN_DEPTH - 1)) begin
              issued_all <= 1'b1;
            end else begin
              srch_idx <= srch_idx + SW'(1);
            end
          end
          cmp_v <= !issued_all;
          if (cmp_v && ring_q == key) begin
            hit <= 1'b1;
          end
          if (issued_all && !cmp_v) begin
            state <= ret;
          end
        end
        S_DECIDE: begin
          verdict.kind         <= lagr_pkg::KIND_VERDICT;
          verdict.out_seq      <= w.seq;
          verdict.history_slot <= 8'd0;
          verdict.deliver      <= !hit;
          verdict.duplicate    <= hit;
          verdict.last         <= 1'b1;
          verdict.gap_seen     <= 1'b0;
          verdict.refilled     <= 1'b0;
          state                <= S_VERDICT;
          if (!hit) begin
            seen_pos <= (seen_pos == SW'(SEEN_DEPTH - 1)) ? '0 : seen_pos + SW'(1);
            verdict.refilled <= any_received && (w.seq < newest_seq);
            if (any_received && (w.seq > newest_seq) && (diff > 32'd1)) begin
              verdict.gap_seen <= 1'b1;
              gap_rem <= (diff_m1 > 32'(cfg.gap_request_cap)) ? cfg.gap_request_cap
                                                                 : diff_m1[8:0];
              gap_seq <= w.seq - 32'd1;
              state   <= S_GAP;
            end
            if (!any_received || w.seq > newest_seq) begin
              newest_seq <= w.seq;
            end
            any_received <= 1'b1;
          end
        end
        S_GAP: begin
          if (gap_rem == 9'd0) begin
            state <= S_VERDICT;
          end else begin
            gap_rem <= gap_rem - 9'd1;
            gap_seq <= gap_seq - 32'd1;
          end
        end
        S_VERDICT: begin
          if (!out_full) begin
            state <= S_IDLE;
          end
        end
        S_SC_CHECK: begin
          state <= (sc_count != '0) ? S_SC_DATA : S_RX_CHECK;
        end
        S_SC_DATA: begin
          if (frame_tick >= sc_q[95:32]) begin
            key        <= sc_q[31:0];
            srch_idx   <= '0;
            issued_all <= 1'b0;
            cmp_v      <= 1'b0;
            hit        <= 1'b0;
            ret        <= S_SC_AFTER;
            state      <= S_SRCH;
          end else begin
            state <= S_RX_CHECK;
          end
        end
        S_SC_AFTER: begin
          sc_head  <= (sc_head == QW'(REQ_QUEUE_DEPTH - 1)) ? '0 : sc_head + QW'(1);
          sc_count <= sc_count - QCW'(1);
          state    <= S_SC_CHECK;
        end
        S_RX_CHECK: begin
          state <= rq_re ? S_RX_DATA : S_FIN;
        end
        S_RX_DATA: begin
          cur_seq  <= rq_q;
          rq_head  <= (rq_head == QW'(REQ_QUEUE_DEPTH - 1)) ? '0 : rq_head + QW'(1);
          rq_count <= rq_count - QCW'(1);
          state    <= S_RX_HIST;
        end
        S_RX_HIST: begin
          if (!order_ok) begin
            state <= S_RX_CHECK;
          end else if (can_go) begin
            // hold each order until the next one shows whether it is the last
            pend_seq   <= cur_seq;
            pend_valid <= 1'b1;
            n          <= n + 2'd1;
            if (sc_we) begin
              sc_tail  <= (sc_tail == QW'(REQ_QUEUE_DEPTH - 1)) ? '0 : sc_tail + QW'(1);
              sc_count <= sc_count + QCW'(1);
            end
            state <= S_RX_CHECK;
          end
        end
        S_FIN: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (!out_full) begin
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    out_wr |-> !out_full) else $error("result written into full queue");
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_count <= QCW'(REQ_QUEUE_DEPTH)) else $error("request queue overfilled");
  a_no_work_while_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !wq_pop) else $error("work taken during ring clear");
  a_one_queue_op: assert property (@(posedge clk) disable iff (rst)
    !(rq_we && rq_re)) else $error("request queue push and pop together");
`endif

endmodule
`default_nettype wire

/* rtl/link_arq_gap_retransmit_unit.sv */
`default_nettype none
// A sent item writes its history slot. A received item with ARQ on walks the dedup ring
// one entry per cycle and may queue gap requests; with ARQ off it skips the search.
// A pump item searches the ring for each due second copy, then issues queued orders.
// The engine takes one item at a time; a two-entry work queue and a four-entry result
// queue decouple the ports. Reset is synchronous; the ring clear after it holds full high.
// HIST_DEPTH must be a power of two; the block does not check it.
// ----------------------------------------------------------------------------
// link_arq_gap_retransmit_unit
// Selective-repeat ARQ with sequence gap detection and retransmit scheduling.
// ----------------------------------------------------------------------------
module link_arq_gap_retransmit_unit #(
  parameter int HIST_DEPTH      = 256,
  parameter int REQ_QUEUE_DEPTH = 512,
  parameter int SEEN_DEPTH      = 512,
  parameter int TX_CREDITS      = 2
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  lagr_pkg::in_t   item,
  output logic            full,
  input  wire             pop,
  output logic            empty,
  output lagr_pkg::out_t  result,
  input  wire             cfg_we,
  input  wire [1:0]       cfg_idx,
  input  wire [8:0]       cfg_data
);

  lagr_pkg::cfg_t  cfg;
  logic            wq_empty;
  lagr_pkg::work_t wq_data;
  logic            wq_pop;
  logic            clearing;
  logic            out_wr;
  lagr_pkg::out_t  out_data;
  logic            out_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.arq_enable        <= 1'b1;
      cfg.retry_limit       <= 4'd3;
      cfg.second_copy_delay <= 8'd16;
      cfg.gap_request_cap   <= 9'd128;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        lagr_pkg::REG_ARQ_ENABLE:  cfg.arq_enable        <= cfg_data[0];
        lagr_pkg::REG_RETRY_LIMIT: cfg.retry_limit       <= cfg_data[3:0];
        lagr_pkg::REG_SECOND_DLY:  cfg.second_copy_delay <= cfg_data[7:0];
        lagr_pkg::REG_GAP_CAP:     cfg.gap_request_cap   <= cfg_data;
        default: ;
      endcase
    end
  end

  lagr_front #(.TX_CREDITS(TX_CREDITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item       (item),
    .full       (full),
    .hold       (clearing),
    .arq_enable (cfg.arq_enable),
    .wq_empty   (wq_empty),
    .wq_data    (wq_data),
    .wq_pop     (wq_pop)
  );

  lagr_engine #(
    .HIST_DEPTH      (HIST_DEPTH),
    .REQ_QUEUE_DEPTH (REQ_QUEUE_DEPTH),
    .SEEN_DEPTH      (SEEN_DEPTH)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .wq_empty (wq_empty),
    .wq_data  (wq_data),
    .wq_pop   (wq_pop),
    .clearing (clearing),
    .out_wr   (out_wr),
    .out_data (out_data),
    .out_full (out_full)
  );

  lagr_out_fifo u_out (
    .clk    (clk),
    .rst    (rst),
    .wr     (out_wr),
    .wdata  (out_data),
    .ofull  (out_full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule
`default_nettype wire
